@@ hw/rtl/partial_rotary_embedding_defines.svh @@
// ----------------------------------------------------------------------------
// Partial rotary embedding - assertion macros
// Clocked assertion helpers, empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef PARTIAL_ROTARY_EMBEDDING_DEFINES_SVH
`define PARTIAL_ROTARY_EMBEDDING_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define PRE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pre assertion failed");
// condition must never be seen outside reset
`define PRE_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("pre forbidden condition seen");
`else
`define PRE_ASSERT(lbl, prop)
`define PRE_NEVER(lbl, cond)
`endif

`endif

@@ hw/rtl/pre_pkg.sv @@
// ----------------------------------------------------------------------------
// pre_pkg
// Shared widths, default parameters and types of the rotary embedding block.
// ----------------------------------------------------------------------------
package pre_pkg;

  localparam int DataW    = 16;  // Q10.6 raw bits
  localparam int FracBits = 6;
  localparam int IndexW   = 12;
  localparam int TabIdxW  = 5;
  localparam int ProdW    = 2 * DataW;

  localparam int DefHiddenLength = 2560;
  localparam int DefHeadLength   = 80;
  localparam int DefRotarySpan   = 32;
  localparam int QueueDepth      = 4;

  typedef enum logic [0:0] {
    FUNC_TABLE = 1'b0,
    FUNC_ELEM  = 1'b1
  } pre_func_e;

  typedef enum logic [0:0] {
    KIND_PASS = 1'b0,
    KIND_ROT  = 1'b1
  } pre_kind_e;

  // classified work item handed from front to back
  typedef struct packed {
    pre_kind_e          kind;
    logic [IndexW-1:0]  pos;
    logic [DataW-1:0]   xh;
    logic [DataW-1:0]   xl;
    logic [DataW-1:0]   cl;
    logic [DataW-1:0]   sl;
    logic [DataW-1:0]   ch;
    logic [DataW-1:0]   sh;
  } pre_item_t;

endpackage

@@ hw/rtl/pre_front.sv @@
// ----------------------------------------------------------------------------
// pre_front
// Accepts input transfers, owns the tables and low-half buffer, tracks the
// stream position and hands classified items to the queue.
// ----------------------------------------------------------------------------
module pre_front #(
  parameter int HIDDEN_LENGTH = pre_pkg::DefHiddenLength,
  parameter int HEAD_LENGTH   = pre_pkg::DefHeadLength,
  parameter int ROTARY_SPAN   = pre_pkg::DefRotarySpan
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           func_i,
  input  logic [pre_pkg::TabIdxW-1:0]    table_index_i,
  input  logic signed [pre_pkg::DataW-1:0] cos_value_i,
  input  logic signed [pre_pkg::DataW-1:0] sin_value_i,
  input  logic signed [pre_pkg::DataW-1:0] element_value_i,
  input  logic                           q_full_i,
  output logic                           push_o,
  output pre_pkg::pre_item_t             item_o
);
  import pre_pkg::*;

  localparam int Half     = ROTARY_SPAN / 2;
  localparam int TabDepth = 2 * Half;
  localparam int TabW     = (TabDepth > 1) ? $clog2(TabDepth) : 1;
  localparam int HalfW    = (Half > 1) ? $clog2(Half) : 1;
  localparam int DimW     = $clog2(HEAD_LENGTH);
  localparam int PosW     = $clog2(HIDDEN_LENGTH);

  logic [DataW-1:0] cos_mem [TabDepth];
  logic [DataW-1:0] sin_mem [TabDepth];
  logic [DataW-1:0] low_mem [Half];

  logic [DimW-1:0]   dim_q, dim_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic              f_valid_q, f_valid_d;
  pre_kind_e         f_kind_q;
  logic [IndexW-1:0] f_pos_q;
  logic [DataW-1:0]  f_xh_q;
  logic [DataW-1:0]  xl_q, cl_q, sl_q, ch_q, sh_q;

  logic accept, is_elem, is_low, is_rot, load_f, tab_wr;
  logic [TabW-1:0]  lo_addr, hi_addr;
  logic [HalfW-1:0] buf_addr_wr, buf_addr_rd;

  assign in_ready_o = !f_valid_q || !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_elem    = (func_i == FUNC_ELEM);
  assign is_low     = 32'(dim_q) < Half;
  assign is_rot     = !is_low && (32'(dim_q) < TabDepth);
  assign load_f     = accept && is_elem && !is_low;
  assign tab_wr     = accept && !is_elem && (32'(table_index_i) < TabDepth);

  // j = dim - Half for the low entries, dim itself for the high entries
  assign lo_addr     = TabW'(32'(dim_q) - Half);
  assign hi_addr     = TabW'(dim_q);
  assign buf_addr_wr = HalfW'(dim_q);
  assign buf_addr_rd = HalfW'(32'(dim_q) - Half);

  // stream position
  always_comb begin
    dim_d = dim_q;
    pos_d = pos_q;
    if (accept && is_elem) begin
      dim_d = (32'(dim_q) == HEAD_LENGTH - 1) ? '0 : dim_q + 1'b1;
      if (32'(pos_q) == HIDDEN_LENGTH - 1) begin
        pos_d = '0;
        dim_d = '0;
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_comb begin
    f_valid_d = f_valid_q;
    if (load_f) begin
      f_valid_d = 1'b1;
    end else if (push_o) begin
      f_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q     <= '0;
      pos_q     <= '0;
      f_valid_q <= 1'b0;
    end else begin
      dim_q     <= dim_d;
      pos_q     <= pos_d;
      f_valid_q <= f_valid_d;
    end
  end

  // item stage payload
  always_ff @(posedge clk_i) begin
    if (load_f) begin
      f_kind_q <= is_rot ? KIND_ROT : KIND_PASS;
      f_pos_q  <= IndexW'(pos_q);
      f_xh_q   <= element_value_i;
    end
  end

  // tables: one write port, two read ports
  always_ff @(posedge clk_i) begin
    if (tab_wr) begin
      cos_mem[TabW'(table_index_i)] <= cos_value_i;
      sin_mem[TabW'(table_index_i)] <= sin_value_i;
    end
    if (load_f && is_rot) begin
      cl_q <= cos_mem[lo_addr];
      sl_q <= sin_mem[lo_addr];
      ch_q <= cos_mem[hi_addr];
      sh_q <= sin_mem[hi_addr];
    end
  end

  // low-half buffer
  always_ff @(posedge clk_i) begin
    if (accept && is_elem && is_low) begin
      low_mem[buf_addr_wr] <= element_value_i;
    end
    if (load_f && is_rot) begin
      xl_q <= low_mem[buf_addr_rd];
    end
  end

  assign push_o = f_valid_q && !q_full_i;

  always_comb begin
    item_o.kind = f_kind_q;
    item_o.pos  = f_pos_q;
    item_o.xh   = f_xh_q;
    item_o.xl   = xl_q;
    item_o.cl   = cl_q;
    item_o.sl   = sl_q;
    item_o.ch   = ch_q;
    item_o.sh   = sh_q;
  end

endmodule

@@ hw/rtl/pre_queue.sv @@
// ----------------------------------------------------------------------------
// pre_queue
// Small FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
`include "partial_rotary_embedding_defines.svh"

module pre_queue #(
  parameter int Depth = pre_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pre_pkg::pre_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output pre_pkg::pre_item_t item_o
);
  import pre_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  pre_item_t          slot_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]    count_q;

  assign full_o  = (32'(count_q) == Depth);
  assign valid_o = (count_q != '0);
  assign item_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (32'(wr_ptr_q) == Depth - 1) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (32'(rd_ptr_q) == Depth - 1) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  `PRE_NEVER(a_no_overflow, push_i && full_o)
  `PRE_NEVER(a_no_underflow, pop_i && !valid_o)
  `PRE_ASSERT(a_count_up, push_i && !pop_i |=> count_q == $past(count_q) + 1'b1)

endmodule

@@ hw/rtl/pre_back.sv @@
// ----------------------------------------------------------------------------
// pre_back
// Product stage and output stage; a rotated item leaves as lo then hi.
// ----------------------------------------------------------------------------
`include "partial_rotary_embedding_defines.svh"

module pre_back #(
  parameter int ROTARY_SPAN = pre_pkg::DefRotarySpan
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             q_valid_i,
  input  pre_pkg::pre_item_t               q_item_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [pre_pkg::IndexW-1:0]       out_index_o,
  output logic signed [pre_pkg::DataW-1:0] out_value_o,
  output logic                             last_o
);
  import pre_pkg::*;

  localparam int Half = ROTARY_SPAN / 2;

  // product stage
  logic                     p_valid_q;
  pre_kind_e                p_kind_q;
  logic [IndexW-1:0]        p_pos_q;
  logic [DataW-1:0]         p_x_q;
  logic signed [ProdW-1:0]  p_lc_q, p_hs_q, p_hc_q, p_ls_q;

  // output stage
  logic                     o_valid_q, o_hi_pend_q, o_last_q;
  logic [IndexW-1:0]        o_idx_q, o_hi_idx_q;
  logic [DataW-1:0]         o_val_q, o_hi_val_q;

  logic                     o_take, p_adv, out_xfer;
  logic signed [ProdW-1:0]  lo_sum, hi_sum;

  assign out_xfer = o_valid_q && out_ready_i;
  assign o_take   = !o_valid_q || (out_ready_i && !o_hi_pend_q);
  assign p_adv    = p_valid_q && o_take;
  assign pop_o    = q_valid_i && (!p_valid_q || p_adv);

  // only bits [21:6] survive, so a 32-bit wrapping sum is exact enough
  assign lo_sum = p_lc_q - p_hs_q;
  assign hi_sum = p_hc_q + p_ls_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q   <= 1'b0;
      o_valid_q   <= 1'b0;
      o_hi_pend_q <= 1'b0;
    end else begin
      if (pop_o) begin
        p_valid_q <= 1'b1;
      end else if (p_adv) begin
        p_valid_q <= 1'b0;
      end
      if (out_xfer && o_hi_pend_q) begin
        o_hi_pend_q <= 1'b0;
      end else if (p_adv) begin
        o_valid_q   <= 1'b1;
        o_hi_pend_q <= (p_kind_q == KIND_ROT);
      end else if (out_ready_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      p_kind_q <= q_item_i.kind;
      p_pos_q  <= q_item_i.pos;
      p_x_q    <= q_item_i.xh;
      p_lc_q   <= $signed(q_item_i.xl) * $signed(q_item_i.cl);
      p_hs_q   <= $signed(q_item_i.xh) * $signed(q_item_i.sl);
      p_hc_q   <= $signed(q_item_i.xh) * $signed(q_item_i.ch);
      p_ls_q   <= $signed(q_item_i.xl) * $signed(q_item_i.sh);
    end
    if (out_xfer && o_hi_pend_q) begin
      o_idx_q  <= o_hi_idx_q;
      o_val_q  <= o_hi_val_q;
      o_last_q <= 1'b1;
    end else if (p_adv) begin
      if (p_kind_q == KIND_ROT) begin
        o_idx_q    <= p_pos_q - IndexW'(Half);
        o_val_q    <= lo_sum[FracBits+DataW-1:FracBits];
        o_last_q   <= 1'b0;
        o_hi_idx_q <= p_pos_q;
        o_hi_val_q <= hi_sum[FracBits+DataW-1:FracBits];
      end else begin
        o_idx_q  <= p_pos_q;
        o_val_q  <= p_x_q;
        o_last_q <= 1'b1;
      end
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_index_o = o_idx_q;
  assign out_value_o = o_val_q;
  assign last_o      = o_last_q;

  `PRE_ASSERT(a_pend_valid, o_hi_pend_q |-> o_valid_q)
  `PRE_ASSERT(a_lo_has_hi, o_valid_q && !o_last_q |-> o_hi_pend_q)
  `PRE_ASSERT(a_hi_follows, out_valid_o && out_ready_i && !last_o |=> out_valid_o && last_o)

endmodule

@@ hw/rtl/partial_rotary_embedding.sv @@
// Path: front item register, 4-entry queue (absorbs bursts), product register, output register.
// Throughput: one input transfer per cycle while in_ready_o is high; a rotated element
//   gives two results, a pass-through element one, a table load or low-half element none.
// The output port, one result per cycle while out_ready_i is high, sets the sustained rate.
// Reset: rst_ni clears position counters and all valid flags; tables and buffer are not cleared.
// ----------------------------------------------------------------------------
// partial_rotary_embedding
// Rotate-half rotary position embedding on the first rotary dims of each head
// of a streamed Q10.6 hidden vector; remaining dims pass through.
// ----------------------------------------------------------------------------
module partial_rotary_embedding #(
  parameter int HIDDEN_LENGTH = pre_pkg::DefHiddenLength,
  parameter int HEAD_LENGTH   = pre_pkg::DefHeadLength,
  parameter int ROTARY_SPAN   = pre_pkg::DefRotarySpan
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             func_i,
  input  logic [pre_pkg::TabIdxW-1:0]      table_index_i,
  input  logic signed [pre_pkg::DataW-1:0] cos_value_i,
  input  logic signed [pre_pkg::DataW-1:0] sin_value_i,
  input  logic signed [pre_pkg::DataW-1:0] element_value_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [pre_pkg::IndexW-1:0]       out_index_o,
  output logic signed [pre_pkg::DataW-1:0] out_value_o,
  output logic                             last_o
);
  import pre_pkg::*;

  // Front end: takes each accepted transfer, writes cos/sin tables and the low-half
  // buffer, and for rotary high-half or pass-through elements reads all
  // operands into an item register. Table reads happen at accept time, so a
  // later table load can never disturb an item already in flight.
  logic      q_full, q_push, q_pop, q_valid;
  pre_item_t front_item, back_item;

  pre_front #(
    .HIDDEN_LENGTH (HIDDEN_LENGTH),
    .HEAD_LENGTH   (HEAD_LENGTH),
    .ROTARY_SPAN   (ROTARY_SPAN)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .table_index_i   (table_index_i),
    .cos_value_i     (cos_value_i),
    .sin_value_i     (sin_value_i),
    .element_value_i (element_value_i),
    .q_full_i        (q_full),
    .push_o          (q_push),
    .item_o          (front_item)
  );

  // Queue decouples the two halves: the front keeps streaming while the
  // back sends out each rotated pair as lo then hi.
  pre_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (back_item)
  );

  // Back end: four 16x16 products registered, then the add/sub with
  // floor-by-6 and wrap into the output register; lo goes out first.
  pre_back #(
    .ROTARY_SPAN (ROTARY_SPAN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (back_item),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_index_o (out_index_o),
    .out_value_o (out_value_o),
    .last_o      (last_o)
  );

endmodule
